[rtl/dsd_to_dop_packer_macros.svh]
// Assertion macros for the DSD to DoP packer.
// Used by the top level only; relies on i_clk and i_rst_n in scope.
`ifndef DSD_TO_DOP_PACKER_MACROS_SVH
`define DSD_TO_DOP_PACKER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define DTD_ASSERT_SAME(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define DTD_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

[rtl/dtd_pkg.sv]
// Shared types, constants and helpers for the DSD to DoP packer.
// No dependencies; imported by dtd_ctl and dsd_to_dop_packer.
package dtd_pkg;

    // Block store geometry
    localparam int MAX_BLOCK = 4096;
    localparam int BLK_AW    = $clog2(MAX_BLOCK);
    localparam int BLK_W     = BLK_AW + 1;

    // Field widths
    localparam int POS_W     = 40;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;

    // DoP markers
    localparam logic [BYTE_W-1:0] MARK_A = 8'h05;
    localparam logic [BYTE_W-1:0] MARK_B = 8'hFA;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 3'd0,
        CFG_BIT_ORDER     = 3'd1,
        CFG_PLANAR_LAYOUT = 3'd2,
        CFG_BLOCK_BYTES   = 3'd3,
        CFG_AUDIO_BYTES   = 3'd4
    } t_cfg_idx;

    // Configuration as seen by the packing logic
    typedef struct packed {
        logic [1:0]       channel_count;
        logic             rev_order;
        logic             planar_layout;
        logic [BLK_W-1:0] block_bytes;
        logic [POS_W-1:0] audio_bytes;
    } t_cfg;

    // One frame ready for the output buffer
    typedef struct packed {
        logic              phase;
        logic              two_words;
        logic [BYTE_W-1:0] hi0;
        logic [BYTE_W-1:0] lo0;
        logic [BYTE_W-1:0] hi1;
        logic [BYTE_W-1:0] lo1;
    } t_pack;

    // Mirror the bit order of one byte
    function automatic logic [BYTE_W-1:0] reverse_bits(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] t;
        t = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
        t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
        return t;
    endfunction

endpackage

[rtl/dsd_to_dop_packer.sv]
// DSD to DoP packer. An input item is taken every cycle unless the output backs up.
// The byte that completes a frame is staged in dtd_ctl, then loaded into the output buffer, which drives the word.
// Throughput: 1 byte per cycle in; 1 word per cycle out while the sink is ready, set by the two-entry output buffer.
// Synchronous active-low reset restores default configuration and stream state;
// the channel-0 block store is not cleared and needs no clearing pass.
`include "dsd_to_dop_packer_macros.svh"
module dsd_to_dop_packer
    import dtd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data,
    // Input bytes
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] data_byte
    // DoP words
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [WORD_W-1:0]    m_axis_tdata,   // [31:0] sample_word
    output logic [0:0]           m_axis_tuser,   // [0] channel
    output logic                 m_axis_tlast
);

    t_cfg              r_cfg;
    logic              pk_valid;
    t_pack             pk;
    logic              pk_take;
    logic              out_fire;
    logic              buf_room;
    logic [1:0]        r_cnt;
    logic [WORD_W-1:0] r_word0, r_word1;
    logic              r_ch0,   r_ch1;
    logic              r_last0, r_last1;
    logic [BYTE_W-1:0] marker;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count <= 2'd2;
            r_cfg.rev_order     <= 1'b0;
            r_cfg.planar_layout <= 1'b0;
            r_cfg.block_bytes   <= BLK_W'(MAX_BLOCK);
            r_cfg.audio_bytes   <= {POS_W{1'b1}};
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_data[1:0];
                CFG_BIT_ORDER:     r_cfg.rev_order     <= i_cfg_data[0];
                CFG_PLANAR_LAYOUT: r_cfg.planar_layout <= i_cfg_data[0];
                CFG_BLOCK_BYTES:   r_cfg.block_bytes   <= i_cfg_data[BLK_W-1:0];
                CFG_AUDIO_BYTES:   r_cfg.audio_bytes   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Byte routing and frame staging
    dtd_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .i_data_byte (s_axis_tdata),
        .o_ready     (s_axis_tready),
        .o_pk_valid  (pk_valid),
        .o_pk        (pk),
        .i_pk_take   (pk_take)
    );

    // Output buffer: take a frame once the previous one drains
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign buf_room = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_fire);
    assign pk_take  = pk_valid && buf_room;
    assign marker   = pk.phase ? MARK_B : MARK_A;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (pk_take) begin
            r_cnt <= pk.two_words ? 2'd2 : 2'd1;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Load a new frame or shift the second word forward
    always_ff @(posedge i_clk) begin
        if (pk_take) begin
            r_word0 <= {marker, pk.hi0, pk.lo0, 8'h00};
            r_ch0   <= 1'b0;
            r_last0 <= !pk.two_words;
            r_word1 <= {marker, pk.hi1, pk.lo1, 8'h00};
            r_ch1   <= 1'b1;
            r_last1 <= 1'b1;
        end else if (out_fire) begin
            r_word0 <= r_word1;
            r_ch0   <= r_ch1;
            r_last0 <= r_last1;
        end
    end

    assign m_axis_tvalid   = r_cnt != 2'd0;
    assign m_axis_tdata    = r_word0;
    assign m_axis_tuser[0] = r_ch0;
    assign m_axis_tlast    = r_last0;

    // A channel-0 word that does not end its frame is followed by the channel-1 word
    `DTD_ASSERT_NEXT(a_pair_follows, out_fire && !m_axis_tlast, m_axis_tvalid && m_axis_tuser[0], "channel-1 word missing after channel-0 word")
    // Channel-1 words always close a frame
    `DTD_ASSERT_SAME(a_ch1_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "channel-1 word without last")
    // Every word carries a DoP marker and a zero low byte
    `DTD_ASSERT_SAME(a_word_form, m_axis_tvalid, (m_axis_tdata[7:0] == 8'h00) && ((m_axis_tdata[31:24] == MARK_A) || (m_axis_tdata[31:24] == MARK_B)), "malformed DoP word")

endmodule

[rtl/dtd_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module dtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports, data held until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

[rtl/dtd_ctl.sv]
// Stream state, byte routing and frame staging for the DoP packer.
// Depends on dtd_pkg and dtd_ram (channel-0 block store).
module dtd_ctl
    import dtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_ready,
    output logic              o_pk_valid,
    output t_pack             o_pk,
    input  logic              i_pk_take
);

    // Stream position state
    logic [BLK_AW-1:0] r_off,   n_off;
    logic              r_chan,  n_chan;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic              r_phase, n_phase;

    // Held bytes, no reset
    logic [BYTE_W-1:0] r_held_hi0, n_held_hi0;
    logic [BYTE_W-1:0] r_held_hi1, n_held_hi1;
    logic [BYTE_W-1:0] r_held_lo,  n_held_lo;

    // Staged frame
    logic              r_s1_valid;
    t_pack             r_s1;
    logic              r_s1_from_ram;
    t_pack             n_s1;
    logic              n_from_ram;
    logic              emit;

    // Derived per-item values
    logic              accept;
    logic              two_ch;
    logic              planar_mode;
    logic [BLK_W-1:0]  blk_clamp;
    logic [BLK_W-1:0]  eff_blk;
    logic [BYTE_W-1:0] b;
    logic              ch;
    logic [POS_W-1:0]  pos;
    logic              in_audio;
    logic              odd;
    logic [BLK_W-1:0]  off_inc;
    logic              blk_end;
    logic [BLK_AW-1:0] hi_idx;

    // Block store ports
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_hi;
    logic [BYTE_W-1:0] ram_lo;

    assign o_ready = !r_s1_valid || i_pk_take;
    assign accept  = i_valid && o_ready;

    // Effective configuration
    assign two_ch      = i_cfg.channel_count[1];
    assign planar_mode = i_cfg.planar_layout && two_ch;

    always_comb begin
        if (i_cfg.block_bytes > BLK_W'(MAX_BLOCK)) begin
            blk_clamp = BLK_W'(MAX_BLOCK);
        end else if (i_cfg.block_bytes < BLK_W'(2)) begin
            blk_clamp = BLK_W'(2);
        end else begin
            blk_clamp = i_cfg.block_bytes;
        end
    end
    assign eff_blk = {blk_clamp[BLK_W-1:1], 1'b0};

    // Per-byte position and classification
    assign b        = i_cfg.rev_order ? reverse_bits(i_data_byte) : i_data_byte;
    assign ch       = two_ch ? r_chan : 1'b0;
    assign pos      = planar_mode ? r_pos + POS_W'(r_off) : r_pos;
    assign in_audio = pos < i_cfg.audio_bytes;
    assign odd      = pos[0];
    assign off_inc  = BLK_W'(r_off) + BLK_W'(1);
    assign blk_end  = off_inc >= eff_blk;
    assign hi_idx   = (r_off != '0) ? r_off - BLK_AW'(1) : '0;

    // Route the byte and advance the stream position
    always_comb begin
        n_off      = r_off;
        n_chan     = r_chan;
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_held_hi0 = r_held_hi0;
        n_held_hi1 = r_held_hi1;
        n_held_lo  = r_held_lo;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        emit       = 1'b0;
        n_from_ram = 1'b0;
        n_s1       = '{phase: r_phase, two_words: 1'b0, hi0: r_held_hi0,
                       lo0: b, hi1: r_held_hi1, lo1: b};
        if (accept) begin
            if (planar_mode) begin
                if (!ch) begin
                    ram_we = 1'b1;
                end else if (!odd) begin
                    n_held_hi1 = b;
                end else if (in_audio) begin
                    emit           = 1'b1;
                    ram_re         = 1'b1;
                    n_from_ram     = 1'b1;
                    n_s1.two_words = 1'b1;
                end
                if (blk_end) begin
                    n_off = '0;
                    if (!ch) begin
                        n_chan = 1'b1;
                    end else begin
                        n_chan = 1'b0;
                        n_pos  = r_pos + POS_W'(eff_blk);
                    end
                end else begin
                    n_off  = off_inc[BLK_AW-1:0];
                    n_chan = ch;
                end
            end else begin
                if (!odd) begin
                    if (ch) begin
                        n_held_hi1 = b;
                    end else begin
                        n_held_hi0 = b;
                    end
                end else if (two_ch && !ch) begin
                    n_held_lo = b;
                end else if (in_audio) begin
                    emit           = 1'b1;
                    n_s1.two_words = two_ch;
                    n_s1.lo0       = two_ch ? r_held_lo : b;
                end
                if (two_ch && !ch) begin
                    n_chan = 1'b1;
                end else begin
                    n_chan = 1'b0;
                    n_pos  = pos + POS_W'(1);
                end
            end
            if (emit) begin
                n_phase = !r_phase;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off      <= '0;
            r_chan     <= 1'b0;
            r_pos      <= '0;
            r_phase    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_off   <= n_off;
            r_chan  <= n_chan;
            r_pos   <= n_pos;
            r_phase <= n_phase;
            if (o_ready) begin
                r_s1_valid <= accept && emit;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_held_hi0 <= n_held_hi0;
        r_held_hi1 <= n_held_hi1;
        r_held_lo  <= n_held_lo;
        if (accept && emit) begin
            r_s1          <= n_s1;
            r_s1_from_ram <= n_from_ram;
        end
    end

    // Channel-0 block store
    dtd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_BLOCK)
    ) u_blk_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_off),
        .i_wdata   (b),
        .i_re      (ram_re),
        .i_raddr_a (hi_idx),
        .i_raddr_b (r_off),
        .o_rdata_a (ram_hi),
        .o_rdata_b (ram_lo)
    );

    // Resolve the first word from the store when it was buffered there
    always_comb begin
        o_pk = r_s1;
        if (r_s1_from_ram) begin
            o_pk.hi0 = ram_hi;
            o_pk.lo0 = ram_lo;
        end
    end
    assign o_pk_valid = r_s1_valid;

endmodule
